### hw/rtl/tcg_pkg.sv
// Shared types and constants of the text console glyph renderer.
// Used by tcg_glyph_store and text_console_glyph_renderer; depends on nothing.
package tcg_pkg;

    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int MAX_GLYPHS_DEF   = 256;

    localparam int GLYPH_WIDTH   = 8;
    localparam int CELL_BYTES    = (GLYPH_WIDTH + 1) * 4;
    localparam int STRIDE_W      = 4;
    localparam int STORE_ADDR_W  = 12;
    localparam int OFFSET_W      = 25;

    localparam logic [1:0] CFG_TEXT_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_TEXT_ROWS    = 2'd1;
    localparam logic [1:0] CFG_PITCH_BYTES  = 2'd2;
    localparam logic [1:0] CFG_GLYPH_COUNT  = 2'd3;

    localparam logic [7:0]  TEXT_COLUMNS_RST = 8'd80;
    localparam logic [6:0]  TEXT_ROWS_RST    = 7'd30;
    localparam logic [14:0] PITCH_BYTES_RST  = 15'd4096;
    localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd256;

    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_RETURN  = 8'h0D;

    typedef struct packed {
        logic                    we;
        logic [STORE_ADDR_W-1:0] waddr;
        logic [7:0]              wdata;
        logic                    re;
        logic [STORE_ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

### hw/rtl/tcg_glyph_store.sv
// Glyph row memory: one write port and one registered read port.
// Depends on tcg_pkg for the request struct and the default depth.
module tcg_glyph_store #(
    parameter int DEPTH = tcg_pkg::MAX_GLYPHS_DEF * (2 ** tcg_pkg::STRIDE_W)
) (
    input  logic                clk,
    input  tcg_pkg::store_req_t req,
    output logic [7:0]          rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/text_console_glyph_renderer.sv
// Text console glyph renderer: cursor, glyph store and cell drawing sequencer.
// A load, newline or carriage return word leaves the sequencer idle. A printed character
// passes a multiply stage, then a base add, then emits GLYPH_HEIGHT*4 output words at one
// per cycle while the output is not stalled; the input is stalled until its last word is
// loaded into the output register.
// Reset clears the cursor and loads the register defaults; the glyph store is not cleared.
module text_console_glyph_renderer #(
    parameter int GLYPH_HEIGHT = tcg_pkg::GLYPH_HEIGHT_DEF,
    parameter int MAX_GLYPHS   = tcg_pkg::MAX_GLYPHS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  char_code,
    input  logic [31:0] fg_color,
    input  logic [31:0] bg_color,
    input  logic [3:0]  load_row,
    input  logic [7:0]  load_bits,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [24:0] byte_offset,
    output logic [63:0] pixel_pair,
    output logic        scroll_before,
    output logic        last
);

    // Glyph index width and the width of row * GLYPH_HEIGHT.
    localparam int GW      = $clog2(MAX_GLYPHS);
    localparam int ROWGH_W = 7 + $clog2(GLYPH_HEIGHT + 1);
    localparam logic [tcg_pkg::STRIDE_W-1:0] LAST_ROW =
        tcg_pkg::STRIDE_W'(GLYPH_HEIGHT - 1);
    localparam logic [8:0] MAX_GLYPHS_9 = 9'(MAX_GLYPHS);
    localparam logic [4:0] HEIGHT_5     = 5'(GLYPH_HEIGHT);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_BASE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Configuration registers.
    logic [7:0]  text_columns_reg;
    logic [6:0]  text_rows_reg;
    logic [14:0] pitch_bytes_reg;
    logic [8:0]  glyph_count_reg;

    // Control state.
    logic [1:0]  state_reg, state_next;
    logic [7:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic [1:0]  pair_reg, pair_next;
    logic [tcg_pkg::STRIDE_W-1:0] y_reg, y_next;
    logic        out_valid_reg, out_valid_next;

    // Per-character working registers (payload, no reset).
    logic [GW-1:0]      glyph_reg;
    logic [7:0]         col_reg;
    logic [ROWGH_W-1:0] rowgh_reg;
    logic               scroll_reg;
    logic [31:0]        fg_reg, bg_reg;
    logic [24:0]        prod_reg;
    logic [24:0]        line_reg;
    logic [7:0]         bits_reg;

    // Output register.
    logic [24:0] offset_reg;
    logic [63:0] pair_data_reg;
    logic        scroll_out_reg;
    logic        last_out_reg;

    logic in_accept;
    logic load_en;
    logic emit;
    logic row_end;
    logic word_last;

    // Cursor placement for a printed character.
    logic [7:0] place_col;
    logic [7:0] place_row;
    logic       place_scroll;
    logic [GW-1:0] glyph_pick;

    logic [26:0] prod_full;
    logic [13:0] col_bytes;
    logic [24:0] add_a, add_b, add_sum;
    logic [7:0]  row_bits;
    logic [2:0]  left_sel, right_sel;

    tcg_pkg::store_req_t store_req;
    logic [7:0]          store_q;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // The output register takes a new word when it is empty or being drained.
    assign load_en   = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_EMIT) && load_en;
    assign row_end   = (pair_reg == 2'd3);
    assign word_last = row_end && (y_reg == LAST_ROW);

    // Wrap first, then scroll if the cursor row has run off the screen.
    always_comb
    begin
        place_col    = cursor_col_reg;
        place_row    = cursor_row_reg;
        place_scroll = 1'b0;
        if (place_col >= text_columns_reg)
        begin
            place_col = 8'd0;
            if (place_row != 8'hFF)
            begin
                place_row = place_row + 8'd1;
            end
        end
        if (place_row >= {1'b0, text_rows_reg})
        begin
            place_scroll = 1'b1;
            place_col    = 8'd0;
            place_row    = (text_rows_reg != 7'd0) ? {1'b0, text_rows_reg - 7'd1} : 8'd0;
        end
    end

    // Code zero and codes outside the font fall back to glyph zero.
    always_comb
    begin
        if ((char_code != 8'd0) && ({1'b0, char_code} < glyph_count_reg)
            && ({1'b0, char_code} < MAX_GLYPHS_9))
        begin
            glyph_pick = char_code[GW-1:0];
        end
        else
        begin
            glyph_pick = '0;
        end
    end

    // Offset arithmetic: one multiplier stage, then a single shared adder that forms
    // the cell base once and steps it by one scanline at the end of every glyph row.
    assign prod_full = {{(27 - ROWGH_W){1'b0}}, rowgh_reg} * {12'd0, pitch_bytes_reg};
    assign col_bytes = 14'(col_reg) * 14'(tcg_pkg::CELL_BYTES);
    assign add_a     = (state_reg == ST_BASE) ? prod_reg : line_reg;
    assign add_b     = (state_reg == ST_BASE) ? {11'd0, col_bytes} : {10'd0, pitch_bytes_reg};
    assign add_sum   = add_a + add_b;

    // The first pair of a row comes straight from the memory read register; the
    // other three pairs use the latched copy so the next row can be fetched early.
    assign row_bits  = (pair_reg == 2'd0) ? store_q : bits_reg;
    assign left_sel  = {~pair_reg, 1'b1};
    assign right_sel = {~pair_reg, 1'b0};

    always_comb
    begin
        store_req       = '0;
        store_req.we    = in_accept && kind && ({1'b0, load_row} < HEIGHT_5)
                          && ({1'b0, char_code} < MAX_GLYPHS_9);
        store_req.waddr = tcg_pkg::STORE_ADDR_W'({char_code[GW-1:0], load_row});
        store_req.wdata = load_bits;
        if (state_reg == ST_BASE)
        begin
            store_req.re    = 1'b1;
            store_req.raddr = tcg_pkg::STORE_ADDR_W'({glyph_reg, {tcg_pkg::STRIDE_W{1'b0}}});
        end
        else if (emit && (pair_reg == 2'd0) && (y_reg != LAST_ROW))
        begin
            store_req.re    = 1'b1;
            store_req.raddr = tcg_pkg::STORE_ADDR_W'({glyph_reg, y_reg + 1'b1});
        end
    end

    tcg_glyph_store #(
        .DEPTH (MAX_GLYPHS * (2 ** tcg_pkg::STRIDE_W))
    ) u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (store_q)
    );

    // Sequencer and cursor next state.
    always_comb
    begin
        state_next      = state_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        pair_next       = pair_reg;
        y_next          = y_reg;
        out_valid_next  = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !kind)
                begin
                    if (char_code == tcg_pkg::CODE_NEWLINE)
                    begin
                        cursor_col_next = 8'd0;
                        if (cursor_row_reg != 8'hFF)
                        begin
                            cursor_row_next = cursor_row_reg + 8'd1;
                        end
                    end
                    else if (char_code == tcg_pkg::CODE_RETURN)
                    begin
                        cursor_col_next = 8'd0;
                    end
                    else
                    begin
                        cursor_row_next = place_row;
                        cursor_col_next = (place_col != 8'hFF) ? place_col + 8'd1 : place_col;
                        state_next      = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                pair_next  = 2'd0;
                y_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    pair_next      = pair_reg + 2'd1;
                    if (row_end)
                    begin
                        y_next = y_reg + 1'b1;
                    end
                    if (word_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_columns_reg <= tcg_pkg::TEXT_COLUMNS_RST;
            text_rows_reg    <= tcg_pkg::TEXT_ROWS_RST;
            pitch_bytes_reg  <= tcg_pkg::PITCH_BYTES_RST;
            glyph_count_reg  <= tcg_pkg::GLYPH_COUNT_RST;
            state_reg        <= ST_IDLE;
            cursor_col_reg   <= 8'd0;
            cursor_row_reg   <= 8'd0;
            pair_reg         <= 2'd0;
            y_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    tcg_pkg::CFG_TEXT_COLUMNS: text_columns_reg <= cfg_data[7:0];
                    tcg_pkg::CFG_TEXT_ROWS:    text_rows_reg    <= cfg_data[6:0];
                    tcg_pkg::CFG_PITCH_BYTES:  pitch_bytes_reg  <= cfg_data;
                    tcg_pkg::CFG_GLYPH_COUNT:  glyph_count_reg  <= cfg_data[8:0];
                    default:                   text_columns_reg <= text_columns_reg;
                endcase
            end
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            pair_reg       <= pair_next;
            y_reg          <= y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept && !kind)
        begin
            glyph_reg  <= glyph_pick;
            col_reg    <= place_col;
            rowgh_reg  <= ROWGH_W'(place_row[6:0] * GLYPH_HEIGHT);
            scroll_reg <= place_scroll;
            fg_reg     <= fg_color;
            bg_reg     <= bg_color;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full[24:0];
        end
        if ((state_reg == ST_BASE) || (emit && row_end))
        begin
            line_reg <= add_sum;
        end
        if (emit)
        begin
            if (pair_reg == 2'd0)
            begin
                bits_reg <= store_q;
            end
            // Each pair covers two pixels of four bytes each.
            offset_reg    <= line_reg + {20'd0, pair_reg, 3'b000};
            pair_data_reg <= {row_bits[right_sel] ? fg_reg : bg_reg,
                              row_bits[left_sel]  ? fg_reg : bg_reg};
            scroll_out_reg <= scroll_reg && (pair_reg == 2'd0) && (y_reg == '0);
            last_out_reg   <= word_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_offset   = offset_reg;
    assign pixel_pair    = pair_data_reg;
    assign scroll_before = scroll_out_reg;
    assign last          = last_out_reg;

`ifndef SYNTHESIS
    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && word_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last word");

    a_setup_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_BASE) ##1 (state_reg == ST_EMIT))
        else $error("setup cycles out of order");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (y_reg <= LAST_ROW))
        else $error("glyph row counter ran past the glyph height");

    a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && scroll_out_reg) |-> !last_out_reg)
        else $error("scroll flag on a final word");
`endif

endmodule
